// ===== sv/accel_tilt_from_averaged_samples_assert.svh =====
// Assertion macros for the accelerometer tilt block.
// Used by accel_tilt_from_averaged_samples.sv; no other dependencies.
`ifndef ACCEL_TILT_FROM_AVERAGED_SAMPLES_ASSERT_SVH
`define ACCEL_TILT_FROM_AVERAGED_SAMPLES_ASSERT_SVH

// Property checked on every rising clock edge, masked while reset is held.
`define ATS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ATS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ats_pkg.sv =====
// Shared constants and tables for the accelerometer tilt block.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package ats_pkg;

    // Window and field widths.
    localparam int WINDOW_LEN  = 5;
    localparam int HIST_LEN    = WINDOW_LEN - 1;
    localparam int SAMPLE_BITS = 14;
    localparam int OFF_W       = 16;
    localparam int ROLL_W      = 15;
    localparam int PITCH_W     = 14;

    // Offset-corrected window sum a = sum - WINDOW_LEN * offset.
    localparam int A_W = ((SAMPLE_BITS > OFF_W) ? SAMPLE_BITS : OFF_W)
                         + $clog2(WINDOW_LEN) + 1;
    // CORDIC datapath: a * 256 plus headroom for gain and rotation.
    localparam int C_W    = A_W + 12;
    localparam int SQ_W   = 2 * A_W + 16;
    localparam int ROOT_W = SQ_W / 2;
    localparam int ANG_W  = 34;
    localparam int M_W    = ANG_W - 1;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int DIV_STEPS    = 15;
    localparam int CNT_W        = 5;

    // Radians Q30 to degrees * 64: q = (m * DEG_NUM + D / 2) / D, D = DEG_DIV * 2^30.
    localparam int DEG_NUM_W = 27;
    localparam logic [DEG_NUM_W-1:0] DEG_NUM = 27'd115200000;
    localparam int PROD_W = M_W + DEG_NUM_W;
    localparam logic [PROD_W-1:0] DEG_HALF = PROD_W'(64'd31415 << 29);
    localparam int QN_W = 29;
    localparam logic [15:0] DEG_DIV = 16'd31415;

    localparam logic [DIV_STEPS-1:0] ROLL_MAX  = 15'd11520;
    localparam logic [DIV_STEPS-1:0] PITCH_MAX = 15'd5760;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Configuration register map.
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    localparam logic [ANG_W-1:0] ATAN_SMALL [10] = '{
        34'd843314857, 34'd497837829, 34'd263043837, 34'd133525159, 34'd67021687,
        34'd33543516,  34'd16775851,  34'd8388437,   34'd4194283,   34'd2097149
    };

    // Arctangent of 2^-i in radians, Q30.
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        if (idx < CNT_W'(10)) begin
            val = signed'(ATAN_SMALL[idx[3:0]]);
        end else begin
            val = signed'(ANG_W'(1) << (CNT_W'(30) - idx));
        end
        return val;
    endfunction

endpackage

// ===== sv/ats_sample_if.sv =====
// Request channel carrying one three-axis accelerometer sample.
// Depends on ats_pkg for the sample width.
`timescale 1ns / 1ps

interface ats_sample_if import ats_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

// ===== sv/ats_angle_if.sv =====
// Request channel carrying one roll and pitch result.
// Depends on ats_pkg for the angle widths.
`timescale 1ns / 1ps

interface ats_angle_if import ats_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;

    modport source (output valid, roll_angle, pitch_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

// ===== sv/accel_tilt_from_averaged_samples.sv =====
// Top level: moving-average tilt computation with roll and pitch by CORDIC.
// Depends on ats_pkg, ats_sample_if, ats_angle_if and the assertion macro header.
//
//   channel  | direction | payload                      | handshake
//   s_in     | in        | sample_x, sample_y, sample_z | valid / ready
//   m_out    | out       | roll_angle, pitch_angle      | valid / ready
//   apb      | in        | offset_x/y/z at 0x0/0x4/0x8  | psel, penable, pwrite
//
// One request runs the window sums and squares, the bit-serial square root, then
// twice a CORDIC pass (30 iterations), a degree multiply and a 15-step bit-serial
// divide. The shared CORDIC unit and the divider take the bulk of each request.
// s_in.ready is high only while idle; a result waiting on m_out holds back only
// the hand-off of the next result.
// Reset is synchronous, active low, and clears history, offsets and control.
`timescale 1ns / 1ps

module accel_tilt_from_averaged_samples import ats_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ats_sample_if.sink        s_in,
    ats_angle_if.source       m_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

`include "accel_tilt_from_averaged_samples_assert.svh"

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_LOAD  = 12'b0000_0000_0010,
        ST_SQY   = 12'b0000_0000_0100,
        ST_SQZ   = 12'b0000_0000_1000,
        ST_SQRT  = 12'b0000_0001_0000,
        ST_CINIT = 12'b0000_0010_0000,
        ST_CORD  = 12'b0000_0100_0000,
        ST_MUL   = 12'b0000_1000_0000,
        ST_DIVI  = 12'b0001_0000_0000,
        ST_DIV   = 12'b0010_0000_0000,
        ST_SAT   = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [OFF_W-1:0]       r_off_x, r_off_y, r_off_z;
    logic signed [SAMPLE_BITS-1:0] r_hist_x [HIST_LEN];
    logic signed [SAMPLE_BITS-1:0] r_hist_y [HIST_LEN];
    logic signed [SAMPLE_BITS-1:0] r_hist_z [HIST_LEN];
    logic signed [SAMPLE_BITS-1:0] r_smp_x, r_smp_y, r_smp_z;
    logic signed [A_W-1:0]         r_ax, r_ay, r_az;
    logic [2*A_W-1:0]              r_sq;
    logic [SQ_W-1:0]               r_rem_sq, r_res, r_bit;
    logic [ROOT_W-1:0]             r_root;
    logic signed [C_W-1:0]         r_cx, r_cy;
    logic signed [ANG_W-1:0]       r_ang;
    logic                          r_zero, r_neg, r_phase;
    logic [CNT_W-1:0]              r_cnt;
    logic [PROD_W-1:0]             r_prod;
    logic [DIV_STEPS-1:0]          r_drem, r_dvd, r_quo;
    logic signed [ROLL_W-1:0]      r_roll, r_roll_out;
    logic signed [PITCH_W-1:0]     r_pitch, r_pitch_out;
    logic                          r_out_valid;

    logic cfg_wr, in_acc;

    // Offset-corrected window sum of one axis.
    function automatic logic signed [A_W-1:0] win_sum(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic signed [SAMPLE_BITS-1:0] hist [HIST_LEN],
        input logic signed [OFF_W-1:0]       off
    );
        logic signed [A_W-1:0] acc;
        acc = A_W'(smp) - A_W'(off) * A_W'(WINDOW_LEN);
        for (int k = 0; k < HIST_LEN; k++) begin
            acc = acc + A_W'(hist[k]);
        end
        return acc;
    endfunction

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_OFFSET_X: prdata = 32'(r_off_x);
            REG_OFFSET_Y: prdata = 32'(r_off_y);
            REG_OFFSET_Z: prdata = 32'(r_off_z);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_OFFSET_X: r_off_x <= signed'(pwdata[OFF_W-1:0]);
                REG_OFFSET_Y: r_off_y <= signed'(pwdata[OFF_W-1:0]);
                REG_OFFSET_Z: r_off_z <= signed'(pwdata[OFF_W-1:0]);
                default: ;
            endcase
        end
    end

    // Handshakes.
    assign s_in.ready        = (r_state == ST_IDLE);
    assign in_acc            = s_in.valid && s_in.ready;
    assign m_out.valid       = r_out_valid;
    assign m_out.roll_angle  = r_roll_out;
    assign m_out.pitch_angle = r_pitch_out;

    // Combinational pieces of the iterative units.
    logic [SQ_W-1:0]        sq_trial;
    logic [2*A_W-1:0]       sq_z;
    logic signed [C_W-1:0]  init_x, init_y, step_dx, step_dy;
    logic [M_W-1:0]         ang_mag;
    logic [PROD_W:0]        rnd_sum;
    logic [QN_W-1:0]        qn;
    logic [DIV_STEPS:0]     div_cat;
    logic [DIV_STEPS-1:0]   q_sat;

    assign sq_trial = r_res + r_bit;
    assign sq_z     = (2*A_W)'(r_az) * (2*A_W)'(r_az);
    assign init_y   = r_phase ? -(C_W'(r_ax) <<< 8) : (C_W'(r_ay) <<< 8);
    assign init_x   = r_phase ? C_W'(r_root) : (C_W'(r_az) <<< 8);
    assign step_dx  = r_cy >>> r_cnt;
    assign step_dy  = r_cx >>> r_cnt;
    assign ang_mag  = r_zero ? '0 : (r_ang[ANG_W-1] ? M_W'(-r_ang) : M_W'(r_ang));
    assign rnd_sum  = (PROD_W+1)'(r_prod) + (PROD_W+1)'(DEG_HALF);
    assign qn       = rnd_sum[30 +: QN_W];
    assign div_cat  = {r_drem, r_dvd[DIV_STEPS-1]};

    always_comb begin
        if (!r_phase && r_quo > ROLL_MAX) begin
            q_sat = ROLL_MAX;
        end else if (r_phase && r_quo > PITCH_MAX) begin
            q_sat = PITCH_MAX;
        end else begin
            q_sat = r_quo;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_SQY;
            ST_SQY:   n_state = ST_SQZ;
            ST_SQZ:   n_state = ST_SQRT;
            ST_SQRT:  if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = ST_CINIT;
            ST_CINIT: n_state = ST_CORD;
            ST_CORD:  if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIVI;
            ST_DIVI:  n_state = ST_DIV;
            ST_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = ST_SAT;
            ST_SAT:   n_state = r_phase ? ST_DONE : ST_CINIT;
            ST_DONE:  if (!r_out_valid || m_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state, history and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            for (int k = 0; k < HIST_LEN; k++) begin
                r_hist_x[k] <= '0;
                r_hist_y[k] <= '0;
                r_hist_z[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            // A finished result loads the output slot once it is free.
            if (r_state == ST_DONE && (!r_out_valid || m_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    for (int k = HIST_LEN - 1; k > 0; k--) begin
                        r_hist_x[k] <= r_hist_x[k-1];
                        r_hist_y[k] <= r_hist_y[k-1];
                        r_hist_z[k] <= r_hist_z[k-1];
                    end
                    r_hist_x[0] <= r_smp_x;
                    r_hist_y[0] <= r_smp_y;
                    r_hist_z[0] <= r_smp_z;
                    r_phase     <= 1'b0;
                end
                ST_SQZ:   r_cnt <= '0;
                ST_CINIT: r_cnt <= '0;
                ST_DIVI:  r_cnt <= '0;
                ST_SQRT, ST_CORD, ST_DIV: r_cnt <= r_cnt + 1'b1;
                ST_SAT:   r_phase <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_smp_x <= s_in.sample_x;
                r_smp_y <= s_in.sample_y;
                r_smp_z <= s_in.sample_z;
            end
            ST_LOAD: begin
                r_ax <= win_sum(r_smp_x, r_hist_x, r_off_x);
                r_ay <= win_sum(r_smp_y, r_hist_y, r_off_y);
                r_az <= win_sum(r_smp_z, r_hist_z, r_off_z);
            end
            ST_SQY: r_sq <= (2*A_W)'(r_ay) * (2*A_W)'(r_ay);
            ST_SQZ: begin
                r_rem_sq <= SQ_W'(r_sq + sq_z) << 16;
                r_res    <= '0;
                r_bit    <= SQ_W'(1) << (SQ_W - 2);
            end
            // One result bit per cycle.
            ST_SQRT: begin
                if (r_rem_sq >= sq_trial) begin
                    r_rem_sq <= r_rem_sq - sq_trial;
                    r_res    <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            // Pre-rotate a vector in the left half plane by a quarter turn.
            ST_CINIT: begin
                r_root <= r_res[ROOT_W-1:0];
                r_zero <= (init_x == '0) && (init_y == '0);
                if (init_x < 0) begin
                    if (init_y >= 0) begin
                        r_cx  <= init_y;
                        r_cy  <= -init_x;
                        r_ang <= HALF_PI_Q30;
                    end else begin
                        r_cx  <= -init_y;
                        r_cy  <= init_x;
                        r_ang <= -HALF_PI_Q30;
                    end
                end else begin
                    r_cx  <= init_x;
                    r_cy  <= init_y;
                    r_ang <= '0;
                end
            end
            ST_CORD: begin
                if (r_cy > 0) begin
                    r_cx  <= r_cx + step_dx;
                    r_cy  <= r_cy - step_dy;
                    r_ang <= r_ang + atan_entry(r_cnt);
                end else begin
                    r_cx  <= r_cx - step_dx;
                    r_cy  <= r_cy + step_dy;
                    r_ang <= r_ang - atan_entry(r_cnt);
                end
            end
            ST_MUL: begin
                r_neg  <= r_ang[ANG_W-1] && !r_zero;
                r_prod <= PROD_W'(ang_mag) * PROD_W'(DEG_NUM);
            end
            // The upper quotient bits are known zero, so the divide starts mid-word.
            ST_DIVI: begin
                r_drem <= DIV_STEPS'(qn[QN_W-1:DIV_STEPS]);
                r_dvd  <= qn[DIV_STEPS-1:0];
                r_quo  <= '0;
            end
            ST_DIV: begin
                if (div_cat >= DEG_DIV) begin
                    r_drem <= DIV_STEPS'(div_cat - DEG_DIV);
                    r_quo  <= {r_quo[DIV_STEPS-2:0], 1'b1};
                end else begin
                    r_drem <= div_cat[DIV_STEPS-1:0];
                    r_quo  <= {r_quo[DIV_STEPS-2:0], 1'b0};
                end
                r_dvd <= r_dvd << 1;
            end
            ST_SAT: begin
                if (!r_phase) begin
                    r_roll <= r_neg ? signed'(ROLL_W'(0) - ROLL_W'(q_sat))
                                    : signed'(ROLL_W'(q_sat));
                end else begin
                    r_pitch <= r_neg ? signed'(PITCH_W'(0) - PITCH_W'(q_sat))
                                     : signed'(PITCH_W'(q_sat));
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_out.ready) begin
                    r_roll_out  <= r_roll;
                    r_pitch_out <= r_pitch;
                end
            end
            default: ;
        endcase
    end

    // Checks on the sequencer and the result.
    `ATS_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n) |=> (r_state == ST_IDLE && !r_out_valid), "reset did not return to idle")
    `ATS_ASSERT_RST(a_accept_load, i_clk, i_rst_n, in_acc |=> (r_state == ST_LOAD), "accepted request did not start")
    `ATS_ASSERT_RST(a_valid_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == ST_DONE), "result raised outside hand-off")
    `ATS_ASSERT_RST(a_div_count, i_clk, i_rst_n, (r_state == ST_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)), "divider ran past its steps")
    `ATS_ASSERT_RST(a_pitch_range, i_clk, i_rst_n, r_out_valid |-> (r_pitch_out <= signed'(PITCH_W'(PITCH_MAX)) && r_pitch_out >= -signed'(PITCH_W'(PITCH_MAX))), "pitch out of range")

endmodule
